// ===== hdl/slc_pkg.sv =====
package slc_pkg;

  localparam int NEWLINE_COUNT_MAX_DEF = 255;

  // Result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // Line phase codes
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_HASH  = 2'd1;
  localparam logic [1:0] PH_LINE  = 2'd2;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef struct packed {
    logic [1:0] phase;
    logic       held_vld;
    logic       held_pct;   // held byte is '%' when set, backslash otherwise
    logic [7:0] pend;
    logic       skip_lf;
  } state_t;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] extra;
    logic       run_last;
    logic       done;
  } res_t;

  typedef struct packed {
    logic [1:0]       cnt;
    res_t [1:0]       res;
  } step_out_t;

endpackage

// ===== hdl/slc_step.sv =====
module slc_step #(
  parameter int NEWLINE_COUNT_MAX = slc_pkg::NEWLINE_COUNT_MAX_DEF
) (
  input  slc_pkg::state_t    state_i,
  input  logic [7:0]         in_byte,
  input  logic               in_last,
  output slc_pkg::state_t    state_o,
  output slc_pkg::step_out_t res_o
);

  localparam logic [7:0] CountCap = (NEWLINE_COUNT_MAX > 255) ? 8'd255 :
                                    8'(NEWLINE_COUNT_MAX);

  function automatic slc_pkg::step_out_t push(slc_pkg::step_out_t o, logic [7:0] d,
                                              logic [7:0] e);
    slc_pkg::step_out_t r;
    r = o;
    r.res[o.cnt[0]].data     = d;
    r.res[o.cnt[0]].extra    = e;
    r.res[o.cnt[0]].run_last = 1'b0;
    r.res[o.cnt[0]].done     = 1'b0;
    r.cnt                    = o.cnt + 2'd1;
    return r;
  endfunction

  slc_pkg::state_t    st;
  slc_pkg::step_out_t o;
  logic               inl;
  logic               blank;
  logic [7:0]         splice_pend;

  assign blank       = (in_byte == slc_pkg::CH_SP) || (in_byte == slc_pkg::CH_TAB);
  assign splice_pend = (state_i.pend < CountCap) ? state_i.pend + 8'd1 : state_i.pend;

  always_comb begin
    st         = state_i;
    o          = '0;
    inl        = 1'b0;
    st.skip_lf = 1'b0;
    if (!(state_i.skip_lf && in_byte == slc_pkg::CH_LF)) begin
      if (state_i.held_vld) begin
        st.held_vld = 1'b0;
        if (state_i.held_pct) begin
          if (in_byte == slc_pkg::CH_COLON) begin
            o        = push(o, slc_pkg::CH_HASH, 8'd0);
            st.phase = slc_pkg::PH_HASH;
          end else begin
            o        = push(o, slc_pkg::CH_PCT, 8'd0);
            st.phase = slc_pkg::PH_LINE;
            inl      = 1'b1;
          end
        end else if (in_byte == slc_pkg::CH_LF) begin
          st.pend = splice_pend;
        end else if (in_byte == slc_pkg::CH_CR) begin
          st.pend    = splice_pend;
          st.skip_lf = 1'b1;
        end else begin
          o   = push(o, slc_pkg::CH_BSL, 8'd0);
          inl = 1'b1;
        end
      end else begin
        case (state_i.phase)
          slc_pkg::PH_START: begin
            if (blank) begin
              // drop leading blank
            end else if (in_byte == slc_pkg::CH_HASH) begin
              o        = push(o, slc_pkg::CH_HASH, 8'd0);
              st.phase = slc_pkg::PH_HASH;
            end else if (in_byte == slc_pkg::CH_PCT) begin
              st.held_vld = 1'b1;
              st.held_pct = 1'b1;
            end else begin
              st.phase = slc_pkg::PH_LINE;
              inl      = 1'b1;
            end
          end
          slc_pkg::PH_HASH: begin
            if (!blank) begin
              st.phase = slc_pkg::PH_LINE;
              inl      = 1'b1;
            end
          end
          default: inl = 1'b1;
        endcase
      end
    end

    if (inl) begin
      if (in_byte == slc_pkg::CH_BSL) begin
        st.held_vld = 1'b1;
        st.held_pct = 1'b0;
      end else if (in_byte == slc_pkg::CH_CR || in_byte == slc_pkg::CH_LF) begin
        o          = push(o, slc_pkg::CH_LF, st.pend);
        st.pend    = 8'd0;
        st.phase   = slc_pkg::PH_START;
        st.skip_lf = (in_byte == slc_pkg::CH_CR);
      end else begin
        o = push(o, in_byte, 8'd0);
      end
    end

    // flush held lookahead and return to reset state at end of text
    if (in_last) begin
      if (st.held_vld) begin
        o = push(o, st.held_pct ? slc_pkg::CH_PCT : slc_pkg::CH_BSL, 8'd0);
      end
      st = '{phase: slc_pkg::PH_START, held_vld: 1'b0, held_pct: 1'b0,
             pend: 8'd0, skip_lf: 1'b0};
    end

    if (o.cnt != 2'd0) begin
      o.res[o.cnt[1]].run_last = 1'b1;
      o.res[o.cnt[1]].done     = in_last;
    end
  end

  assign state_o = st;
  assign res_o   = o;

endmodule

// ===== hdl/slc_outq.sv =====
module slc_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  slc_pkg::step_out_t          push_res,
  input  logic                        pop,
  output logic                        head_vld,
  output slc_pkg::res_t               head,
  output logic [slc_pkg::QCW-1:0]     fill
);

  slc_pkg::res_t                 mem [slc_pkg::QDEPTH];
  logic [slc_pkg::QAW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [slc_pkg::QAW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [slc_pkg::QCW-1:0]       count_r, count_nxt;
  logic [1:0]                    n_push;
  logic                          do_pop;

  assign n_push     = push ? push_res.cnt : 2'd0;
  assign do_pop     = pop && (count_r != '0);
  assign wr_ptr_nxt = wr_ptr_r + slc_pkg::QAW'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + slc_pkg::QAW'(do_pop);
  assign count_nxt  = count_r + slc_pkg::QCW'(n_push) - slc_pkg::QCW'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr_r] <= push_res.res[0];
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_r + slc_pkg::QAW'(1)] <= push_res.res[1];
    end
  end

  assign head_vld = (count_r != '0);
  assign head     = mem[rd_ptr_r];
  assign fill     = count_r;

endmodule

// ===== hdl/source_line_cleaner_core.sv =====
// Source line cleaner: takes source text one byte per transaction on the in_
// channel and emits the cleaned byte stream on the out_ channel. Leading
// blanks are dropped, "#"/"%:" directives are normalized, CR-LF and lone CR
// become LF, and backslash-newline splices are removed; the next LF carries
// the splice count in extra_newlines. in_tlast marks the final byte of a
// text: held lookahead is flushed and the state returns to its reset value.
// Each accepted byte is processed in the cycle it is accepted and gives 0 to
// 2 results, which are written into a 4-entry result queue; with the queue
// empty, the first result is on out_ in the cycle after acceptance. The input
// takes one byte per cycle while the queue has two free entries, so throughput
// is one byte per cycle whenever output bytes drain at one per cycle; bytes
// that expand to two results are limited by the single-entry queue read port.
// When the receiver stalls, results are held in the queue and in_tready
// drops once fewer than two entries are free. Synchronous reset (rst_n low)
// empties the queue and puts the line state at line start.
module source_line_cleaner_core #(
  parameter int NEWLINE_COUNT_MAX = slc_pkg::NEWLINE_COUNT_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [15:8] extra_newlines
  output logic        out_tlast,  // run_last
  output logic        out_tuser   // stream_done
);

  localparam logic [7:0] CountCap = (NEWLINE_COUNT_MAX > 255) ? 8'd255 :
                                    8'(NEWLINE_COUNT_MAX);

  slc_pkg::state_t          state_r, state_nxt;
  slc_pkg::step_out_t       step_res;
  slc_pkg::res_t            head;
  logic                     head_vld;
  logic [slc_pkg::QCW-1:0]  fill;
  logic                     in_acc;

  assign in_tready = (fill <= slc_pkg::QCW'(slc_pkg::QDEPTH - 2));
  assign in_acc    = in_tvalid && in_tready;

  slc_step #(
    .NEWLINE_COUNT_MAX(NEWLINE_COUNT_MAX)
  ) u_step (
    .state_i (state_r),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .state_o (state_nxt),
    .res_o   (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: slc_pkg::PH_START, held_vld: 1'b0, held_pct: 1'b0,
                   pend: 8'd0, skip_lf: 1'b0};
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  slc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_acc),
    .push_res (step_res),
    .pop      (out_tready),
    .head_vld (head_vld),
    .head     (head),
    .fill     (fill)
  );

  assign out_tvalid = head_vld;
  assign out_tdata  = {head.extra, head.data};
  assign out_tlast  = head.run_last;
  assign out_tuser  = head.done;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill <= slc_pkg::QCW'(slc_pkg::QDEPTH))
    else $error("result queue overfilled");

  a_pend_cap: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pend <= CountCap)
    else $error("splice count above cap");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> state_r.phase == slc_pkg::PH_START && !state_r.held_vld
                           && state_r.pend == 8'd0 && !state_r.skip_lf)
    else $error("line state not cleared after end of text");

  a_one_per_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc && !(out_tvalid && out_tready) |=> $stable(fill))
    else $error("queue fill moved without a transaction");

endmodule

// ===== tb/sv/source_line_cleaner_core_test.sv =====
`timescale 1ns / 100ps

module source_line_cleaner_core_test;

  localparam int NL_MAX     = slc_pkg::NEWLINE_COUNT_MAX_DEF;
  localparam int SPLICE_CAP = (NL_MAX > 255) ? 255 : NL_MAX;

  typedef struct packed {
    logic [7:0] data;
    logic [7:0] extra;
    logic       run_last;
    logic       done;
  } cleaned_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  int err_cnt  = 0;
  int sent_cnt = 0;

  // line state of the cleaner as the checker sees it
  logic [1:0] line_ph;
  bit         hold_vld;
  logic [7:0] hold_byte;
  logic [7:0] splice_cnt;
  bit         drop_lf;

  cleaned_t step_res[$];
  cleaned_t cleaned_q[$];

  source_line_cleaner_core #(
    .NEWLINE_COUNT_MAX(NL_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  function automatic void clear_line_state();
    line_ph    = slc_pkg::PH_START;
    hold_vld   = 1'b0;
    hold_byte  = 8'd0;
    splice_cnt = 8'd0;
    drop_lf    = 1'b0;
  endfunction

  function automatic void put_res(input logic [7:0] b, input logic [7:0] x);
    cleaned_t r;
    r.data     = b;
    r.extra    = x;
    r.run_last = 1'b0;
    r.done     = 1'b0;
    step_res   = {step_res, r};
  endfunction

  function automatic void count_splice();
    if (splice_cnt < SPLICE_CAP)
      splice_cnt = splice_cnt + 8'd1;
  endfunction

  function automatic bit is_blank(input logic [7:0] b);
    return (b == slc_pkg::CH_SP) || (b == slc_pkg::CH_TAB);
  endfunction

  function automatic void line_byte(input logic [7:0] b);
    if (b == slc_pkg::CH_BSL) begin
      hold_vld  = 1'b1;
      hold_byte = b;
    end else if (b == slc_pkg::CH_CR || b == slc_pkg::CH_LF) begin
      put_res(slc_pkg::CH_LF, splice_cnt);
      splice_cnt = 8'd0;
      line_ph    = slc_pkg::PH_START;
      drop_lf    = (b == slc_pkg::CH_CR);
    end else begin
      put_res(b, 8'd0);
    end
  endfunction

  // Work out the cleaned bytes one accepted input byte produces.
  function automatic void clean_step(input logic [7:0] b, input bit last);
    bit         dropped;
    logic [7:0] h;
    dropped = 1'b0;
    step_res.delete();
    if (drop_lf) begin
      drop_lf = 1'b0;
      dropped = (b == slc_pkg::CH_LF);
    end
    if (!dropped) begin
      if (hold_vld) begin
        h         = hold_byte;
        hold_vld  = 1'b0;
        hold_byte = 8'd0;
        if (h == slc_pkg::CH_PCT) begin
          if (b == slc_pkg::CH_COLON) begin
            put_res(slc_pkg::CH_HASH, 8'd0);
            line_ph = slc_pkg::PH_HASH;
          end else begin
            put_res(slc_pkg::CH_PCT, 8'd0);
            line_ph = slc_pkg::PH_LINE;
            line_byte(b);
          end
        end else if (b == slc_pkg::CH_LF) begin
          count_splice();
        end else if (b == slc_pkg::CH_CR) begin
          count_splice();
          drop_lf = 1'b1;
        end else begin
          put_res(slc_pkg::CH_BSL, 8'd0);
          line_byte(b);
        end
      end else if (line_ph == slc_pkg::PH_START) begin
        if (is_blank(b)) begin
          // drop leading blank
        end else if (b == slc_pkg::CH_HASH) begin
          put_res(slc_pkg::CH_HASH, 8'd0);
          line_ph = slc_pkg::PH_HASH;
        end else if (b == slc_pkg::CH_PCT) begin
          hold_vld  = 1'b1;
          hold_byte = b;
        end else begin
          line_ph = slc_pkg::PH_LINE;
          line_byte(b);
        end
      end else if (line_ph == slc_pkg::PH_HASH) begin
        if (!is_blank(b)) begin
          line_ph = slc_pkg::PH_LINE;
          line_byte(b);
        end
      end else begin
        line_byte(b);
      end
    end
    if (last) begin
      if (hold_vld)
        put_res(hold_byte, 8'd0);
      clear_line_state();
    end
    if (step_res.size() > 0) begin
      step_res[step_res.size() - 1].run_last = 1'b1;
      step_res[step_res.size() - 1].done     = last;
    end
    foreach (step_res[i])
      cleaned_q = {cleaned_q, step_res[i]};
  endfunction

  // Result checker: compare each output transaction with the oldest expected byte.
  always @(posedge clk) begin : check_out
    cleaned_t want;
    cleaned_t got;
    got.data     = out_tdata[7:0];
    got.extra    = out_tdata[15:8];
    got.run_last = out_tlast;
    got.done     = out_tuser;
    if (rst_n && out_tvalid && out_tready) begin
      if (cleaned_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("%0t: unexpected result byte %02h extra %0d last %b done %b",
                   $realtime, got.data, got.extra, got.run_last, got.done);
      end else begin
        want = cleaned_q.pop_front();
        if (want !== got) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("%0t: expected %02h/%0d/%b/%b, got %02h/%0d/%b/%b",
                     $realtime, want.data, want.extra, want.run_last, want.done,
                     got.data, got.extra, got.run_last, got.done);
        end
      end
    end
  end

  // Receiver: ready in runs, with stall bursts while stalling is enabled.
  initial begin : sink_ctl
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (stall_on) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    clean_step(b, last);
    sent_cnt++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == s.len() - 1);
  endtask

  // Build one text from source-like pieces (or pure noise) and send it.
  task automatic send_random_text(input int max_len, input bit noise);
    logic [7:0] txt[$];
    int         len;
    len = $urandom_range(1, max_len);
    while (txt.size() < len) begin
      if (noise) begin
        txt = {txt, 8'($urandom_range(0, 255))};
      end else begin
        case ($urandom_range(0, 17))
          0:  txt = {txt, slc_pkg::CH_SP};
          1:  txt = {txt, slc_pkg::CH_TAB};
          2:  txt = {txt, slc_pkg::CH_HASH};
          3:  txt = {txt, slc_pkg::CH_PCT};
          4:  txt = {txt, slc_pkg::CH_COLON};
          5:  txt = {txt, slc_pkg::CH_BSL};
          6:  txt = {txt, slc_pkg::CH_CR};
          7:  txt = {txt, slc_pkg::CH_LF};
          8:  txt = {txt, slc_pkg::CH_BSL, slc_pkg::CH_LF};
          9:  txt = {txt, slc_pkg::CH_BSL, slc_pkg::CH_CR, slc_pkg::CH_LF};
          10: txt = {txt, slc_pkg::CH_BSL, slc_pkg::CH_CR};
          11: txt = {txt, slc_pkg::CH_CR, slc_pkg::CH_LF};
          12: txt = {txt, slc_pkg::CH_PCT, slc_pkg::CH_COLON};
          13: txt = {txt, 8'($urandom_range(0, 255))};
          default: txt = {txt, 8'($urandom_range(8'h21, 8'h7E))};
        endcase
      end
    end
    foreach (txt[i])
      send_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic test_directed_cases();
    // blanks, '#' with blanks, backslash-CR-LF, backslash-CR alone, lone CR at end
    send_string("\t# x\\\015\n\\\015y\015");
    // digraph, percent without colon, backslash before an ordinary byte, held '%' flush
    send_string("%:a\n%b\\q\n%");
    // zero byte, all-ones byte, held backslash flushed at end
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(slc_pkg::CH_BSL, 1'b1);
    // final byte gives nothing; pending splice is dropped
    send_string("a\\\n");
  endtask

  // Long run of splices paid out on one LF.
  task automatic test_splice_run();
    send_byte("a", 1'b0);
    repeat (40) begin
      send_byte(slc_pkg::CH_BSL, 1'b0);
      send_byte(slc_pkg::CH_LF, 1'b0);
    end
    send_byte(slc_pkg::CH_LF, 1'b0);
    send_byte("z", 1'b1);
  endtask

  task automatic test_random_texts();
    int start;
    start = sent_cnt;
    while (sent_cnt - start < 150)
      send_random_text(30, $urandom_range(0, 5) == 0);
  endtask

  task automatic test_steady_stream();
    int start;
    start = sent_cnt;
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    while (sent_cnt - start < 45)
      send_random_text(20, 1'b0);
  endtask

  task automatic drain_and_settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (cleaned_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (cleaned_q.size() != 0)
      err_cnt++;
    repeat (16) @(posedge clk);
  endtask

  initial begin
    clear_line_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_splice_run();
    test_random_texts();
    test_steady_stream();
    drain_and_settle();
    if (err_cnt == 0 && cleaned_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/slc_pkg.sv
hdl/slc_step.sv
hdl/slc_outq.sv
hdl/source_line_cleaner_core.sv
tb/sv/source_line_cleaner_core_test.sv
